// ===== hw/rtl/ght_pkg.sv =====
// ----------------------------------------------------------------------------
// ght_pkg
// shared types, codes and defaults of the generational handle table
// ----------------------------------------------------------------------------
`default_nettype none

package ght_pkg;

  localparam int unsigned SlotsDef       = 16;
  localparam int unsigned GenBitsDef     = 32;
  localparam int unsigned PayloadBitsDef = 32;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned CtxW    = 32;
  localparam int unsigned HSlotW  = 8;
  localparam int unsigned HGenW   = 32;
  localparam int unsigned NPayW   = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned OSlotW  = 4;
  localparam int unsigned OGenW   = 32;
  localparam int unsigned OPayW   = 32;

  localparam logic [FuncW-1:0] FN_INSERT  = 2'd0;
  localparam logic [FuncW-1:0] FN_LOOKUP  = 2'd1;
  localparam logic [FuncW-1:0] FN_RELEASE = 2'd2;

  localparam logic [StatusW-1:0] ST_OK      = 3'd0;
  localparam logic [StatusW-1:0] ST_INVALID = 3'd1;
  localparam logic [StatusW-1:0] ST_STALE   = 3'd2;
  localparam logic [StatusW-1:0] ST_FOREIGN = 3'd3;
  localparam logic [StatusW-1:0] ST_FULL    = 3'd4;

  localparam logic [CtxW-1:0] OwnContextRst = 32'd1;

  typedef struct packed {
    logic capture;
    logic pick;
    logic commit;
  } ght_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ght_ram.sv =====
// ----------------------------------------------------------------------------
// ght_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module ght_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ght_ctrl.sv =====
// ----------------------------------------------------------------------------
// ght_ctrl
// sequencer: accept, pick slot, commit and strobe the result
// ----------------------------------------------------------------------------
`default_nettype none

module ght_ctrl
  import ght_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  output logic      done_o,
  output ght_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PICK,
    S_COMMIT
  } state_e;

  state_e state_q;
  logic   done_q;
  logic   accept;

  assign accept = start && (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_PICK;
          end
        end
        S_PICK: begin
          state_q <= S_COMMIT;
        end
        S_COMMIT: begin
          state_q <= S_IDLE;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign cmd_o.capture = accept;
  assign cmd_o.pick    = (state_q == S_PICK);
  assign cmd_o.commit  = (state_q == S_COMMIT);

endmodule

`default_nettype wire

// ===== hw/rtl/ght_dp.sv =====
// ----------------------------------------------------------------------------
// ght_dp
// handle table datapath: entry stores, free stack, counters and checks
// ----------------------------------------------------------------------------
`default_nettype none

module ght_dp
  import ght_pkg::*;
#(
  parameter int unsigned SLOTS        = SlotsDef,
  parameter int unsigned GEN_BITS     = GenBitsDef,
  parameter int unsigned PAYLOAD_BITS = PayloadBitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ght_cmd_t            cmd_i,
  input  wire logic                own_context_we_i,
  input  wire logic [CtxW-1:0]     own_context_i,
  input  wire logic [FuncW-1:0]    func_i,
  input  wire logic [CtxW-1:0]     handle_context_i,
  input  wire logic [HSlotW-1:0]   handle_slot_i,
  input  wire logic [HGenW-1:0]    handle_generation_i,
  input  wire logic [NPayW-1:0]    new_payload_i,
  output logic      [StatusW-1:0]  status_o,
  output logic      [OSlotW-1:0]   out_slot_o,
  output logic      [OGenW-1:0]    out_generation_o,
  output logic      [OPayW-1:0]    out_payload_o
);

  localparam int unsigned SlotW = $clog2(SLOTS);
  localparam int unsigned CntW  = $clog2(SLOTS + 1);

  logic [FuncW-1:0]   func_q;
  logic [CtxW-1:0]    hctx_q;
  logic [HSlotW-1:0]  hslot_q;
  logic [HGenW-1:0]   hgen_q;
  logic [NPayW-1:0]   npay_q;
  logic [CtxW-1:0]    own_ctx_q;

  logic [CntW-1:0]    used_mark_q, used_mark_d;
  logic [CntW-1:0]    free_count_q, free_count_d;
  logic [SLOTS-1:0]   occ_q, occ_d;
  logic [SLOTS-1:0]   gen_vld_q, gen_vld_d;

  logic [SlotW-1:0]   slot_q, sel_slot;
  logic               pop_q, room_q;

  logic [StatusW-1:0] status_q, status_d;
  logic [OSlotW-1:0]  oslot_q, oslot_d;
  logic [OGenW-1:0]   ogen_q, ogen_d;
  logic [OPayW-1:0]   opay_q, opay_d;

  logic [CntW-1:0]         fc_m1;
  logic [SlotW-1:0]        stk_rdata;
  logic                    stk_we;
  logic [GEN_BITS-1:0]     gen_rdata, gen_cur, gen_wdata;
  logic                    gen_we;
  logic [PAYLOAD_BITS-1:0] pay_rdata, pay_wdata;
  logic                    pay_we;
  logic [63:0]             pay_in_ext, pay_out_ext;
  logic [7:0]              slot_ext;
  logic                    handle_ok;
  logic                    ctx_ok, range_ok;

  assign fc_m1 = free_count_q - CntW'(1);

  ght_ram #(.WIDTH(SlotW), .DEPTH(SLOTS)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (free_count_q[SlotW-1:0]),
    .wdata_i (slot_q),
    .raddr_i (fc_m1[SlotW-1:0]),
    .rdata_o (stk_rdata)
  );

  ght_ram #(.WIDTH(GEN_BITS), .DEPTH(SLOTS)) u_gen_ram (
    .clk_i   (clk_i),
    .we_i    (gen_we),
    .waddr_i (slot_q),
    .wdata_i (gen_wdata),
    .raddr_i (sel_slot),
    .rdata_o (gen_rdata)
  );

  ght_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(SLOTS)) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .waddr_i (slot_q),
    .wdata_i (pay_wdata),
    .raddr_i (sel_slot),
    .rdata_o (pay_rdata)
  );

  // slot choice: top of free stack, then high-water mark, else the handle
  always_comb begin
    if ((func_q == FN_INSERT) && (free_count_q != '0)) begin
      sel_slot = stk_rdata;
    end else if (func_q == FN_INSERT) begin
      sel_slot = used_mark_q[SlotW-1:0];
    end else begin
      sel_slot = hslot_q[SlotW-1:0];
    end
  end

  assign gen_cur     = gen_vld_q[slot_q] ? gen_rdata : '0;
  assign pay_in_ext  = 64'(npay_q);
  assign pay_out_ext = 64'(pay_rdata);
  assign pay_wdata   = pay_in_ext[PAYLOAD_BITS-1:0];
  assign slot_ext    = 8'(slot_q);

  assign ctx_ok    = (own_ctx_q != '0) && (hctx_q == own_ctx_q);
  assign range_ok  = ({1'b0, hslot_q} < 9'(used_mark_q));
  assign handle_ok = occ_q[slot_q] && (32'(gen_cur) == hgen_q);

  always_comb begin
    status_d     = ST_INVALID;
    oslot_d      = '0;
    ogen_d       = '0;
    opay_d       = '0;
    used_mark_d  = used_mark_q;
    free_count_d = free_count_q;
    occ_d        = occ_q;
    gen_vld_d    = gen_vld_q;
    gen_wdata    = gen_cur;
    gen_we       = 1'b0;
    pay_we       = 1'b0;
    stk_we       = 1'b0;
    if (cmd_i.commit) begin
      unique case (func_q)
        FN_INSERT: begin
          if (pop_q || room_q) begin
            gen_wdata         = (gen_cur == '0) ? GEN_BITS'(1) : gen_cur;
            gen_we            = 1'b1;
            pay_we            = 1'b1;
            occ_d[slot_q]     = 1'b1;
            gen_vld_d[slot_q] = 1'b1;
            if (pop_q) begin
              free_count_d = fc_m1;
            end else begin
              used_mark_d = used_mark_q + CntW'(1);
            end
            status_d = ST_OK;
            oslot_d  = slot_ext[OSlotW-1:0];
            ogen_d   = OGenW'(gen_wdata);
          end else begin
            status_d = ST_FULL;
          end
        end
        FN_LOOKUP, FN_RELEASE: begin
          if (!ctx_ok) begin
            status_d = ST_FOREIGN;
          end else if (!range_ok) begin
            status_d = ST_INVALID;
          end else if (!handle_ok) begin
            status_d = ST_STALE;
          end else begin
            status_d = ST_OK;
            if (func_q == FN_LOOKUP) begin
              opay_d = pay_out_ext[OPayW-1:0];
            end else begin
              occ_d[slot_q]     = 1'b0;
              gen_wdata         = gen_cur + GEN_BITS'(1);
              gen_we            = 1'b1;
              gen_vld_d[slot_q] = 1'b1;
              if (free_count_q < CntW'(SLOTS)) begin
                stk_we       = 1'b1;
                free_count_d = free_count_q + CntW'(1);
              end
            end
          end
        end
        default: begin
          status_d = ST_INVALID;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ctx_q    <= OwnContextRst;
      used_mark_q  <= '0;
      free_count_q <= '0;
      occ_q        <= '0;
      gen_vld_q    <= '0;
    end else begin
      if (own_context_we_i) begin
        own_ctx_q <= own_context_i;
      end
      used_mark_q  <= used_mark_d;
      free_count_q <= free_count_d;
      occ_q        <= occ_d;
      gen_vld_q    <= gen_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q  <= func_i;
      hctx_q  <= handle_context_i;
      hslot_q <= handle_slot_i;
      hgen_q  <= handle_generation_i;
      npay_q  <= new_payload_i;
    end
    if (cmd_i.pick) begin
      slot_q <= sel_slot;
      pop_q  <= (free_count_q != '0);
      room_q <= (used_mark_q < CntW'(SLOTS));
    end
    if (cmd_i.commit) begin
      status_q <= status_d;
      oslot_q  <= oslot_d;
      ogen_q   <= ogen_d;
      opay_q   <= opay_d;
    end
  end

  assign status_o         = status_q;
  assign out_slot_o       = oslot_q;
  assign out_generation_o = ogen_q;
  assign out_payload_o    = opay_q;

endmodule

`default_nettype wire

// ===== hw/rtl/generational_handle_table_core.sv =====
// ----------------------------------------------------------------------------
// generational_handle_table_core
// handle table with generation counters, free stack and context check
//
// channel   signals                                 dir  beat taken when
// command   start, busy, func_i, handle_*_i,        in   start && !busy
//           new_payload_i
// result    done_o, status_o, out_slot_o,           out  done_o
//           out_generation_o, out_payload_o
// config    own_context_we_i, own_context_i         in   own_context_we_i
//
// each command steps through accept, slot pick (free stack read) and
// commit (generation and payload read-modify-write); done_o follows
// and a new command may be accepted in that same cycle.
// the free stack ram read and the entry ram read are in series.
// reset needs no clearing pass.
// the receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
`default_nettype none

module generational_handle_table_core
  import ght_pkg::*;
#(
  parameter int unsigned SLOTS        = SlotsDef,
  parameter int unsigned GEN_BITS     = GenBitsDef,
  parameter int unsigned PAYLOAD_BITS = PayloadBitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                own_context_we_i,
  input  wire logic [CtxW-1:0]     own_context_i,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [FuncW-1:0]    func_i,
  input  wire logic [CtxW-1:0]     handle_context_i,
  input  wire logic [HSlotW-1:0]   handle_slot_i,
  input  wire logic [HGenW-1:0]    handle_generation_i,
  input  wire logic [NPayW-1:0]    new_payload_i,
  output logic                     done_o,
  output logic      [StatusW-1:0]  status_o,
  output logic      [OSlotW-1:0]   out_slot_o,
  output logic      [OGenW-1:0]    out_generation_o,
  output logic      [OPayW-1:0]    out_payload_o
);

  ght_cmd_t cmd;

  ght_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  ght_dp #(
    .SLOTS        (SLOTS),
    .GEN_BITS     (GEN_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .own_context_we_i    (own_context_we_i),
    .own_context_i       (own_context_i),
    .func_i              (func_i),
    .handle_context_i    (handle_context_i),
    .handle_slot_i       (handle_slot_i),
    .handle_generation_i (handle_generation_i),
    .new_payload_i       (new_payload_i),
    .status_o            (status_o),
    .out_slot_o          (out_slot_o),
    .out_generation_o    (out_generation_o),
    .out_payload_o       (out_payload_o)
  );

  // accepted command is busy until its result beat
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 done_o)
    else $error("result beat missing three cycles after accept");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result beat while still busy");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == ST_OK || status_o == ST_INVALID || status_o == ST_STALE ||
                status_o == ST_FOREIGN || status_o == ST_FULL))
    else $error("undefined status code on result beat");

endmodule

`default_nettype wire
